// ===== hw/rtl/pfc_startup_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// pfc_startup_sequencer_defines
// Assertion macros used by the start-up sequencer top level.
// ----------------------------------------------------------------------------
`ifndef PFC_STARTUP_SEQUENCER_DEFINES_SVH
`define PFC_STARTUP_SEQUENCER_DEFINES_SVH

// same-cycle implication, held off while in reset
`define PFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pfc_startup_sequencer: implication violated");

// next-cycle implication, held off while in reset
`define PFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pfc_startup_sequencer: next-cycle implication violated");

`endif

// ===== hw/rtl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// Types and constants of the power-factor-corrector start-up sequencer.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned CapWidth    = 12;
  localparam int unsigned TicksWidth  = 16;
  localparam int unsigned PhaseWidth  = 16;
  localparam int unsigned CountWidth  = 32;
  localparam int unsigned PulseWidth  = 3;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CapWidth-1:0]   PrechargeVoltageRst = CapWidth'(2048);
  localparam logic [TicksWidth-1:0] StartupTicksRst     = TicksWidth'(100);
  localparam logic [TicksWidth-1:0] PreloadTicksRst     = TicksWidth'(50);
  localparam logic [PhaseWidth-1:0] SyncPhaseLimitRst   = PhaseWidth'(1024);

  // charge state is left after this many ticks
  localparam logic [PulseWidth-1:0] ChargeTicks = PulseWidth'(4);

  typedef enum logic [3:0] {
    ST_INIT      = 4'd0,
    ST_STOP      = 4'd1,
    ST_SYNC      = 4'd2,
    ST_PRE_PREP  = 4'd3,
    ST_PRECHARGE = 4'd4,
    ST_MAIN      = 4'd5,
    ST_PRE_DIS   = 4'd6,
    ST_WORK      = 4'd7,
    ST_CHARGE    = 4'd8,
    ST_TEST      = 4'd9,
    ST_STOPPING  = 4'd10,
    ST_FAULT     = 4'd11
  } pfc_state_e;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_FAULT      = 3'd1,
    OP_WORK_ON    = 3'd2,
    OP_WORK_OFF   = 3'd3,
    OP_CHARGE_ON  = 3'd4,
    OP_CHARGE_OFF = 3'd5,
    OP_SAVE       = 3'd6,
    OP_OTHER      = 3'd7
  } pfc_op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_PRECHARGE_VOLTAGE = 2'd0,
    CFG_STARTUP_TICKS     = 2'd1,
    CFG_PRELOAD_TICKS     = 2'd2,
    CFG_SYNC_PHASE_LIMIT  = 2'd3
  } pfc_cfg_idx_e;

  typedef struct packed {
    logic [2:0]            opcode;
    logic [CapWidth-1:0]   cap_voltage;
    logic                  period_stable;
    logic [PhaseWidth-1:0] phase_magnitude;
  } pfc_in_word_t;

  typedef struct packed {
    logic [3:0] fsm_state;
    logic       main_relay_on;
    logic       preload_relay_on;
    logic       fans_on;
    logic       pwm_enabled;
    logic       pwm_restart;
    logic       state_changed;
    logic       save_request;
    logic       command_error;
  } pfc_out_word_t;

  // handshake status between the holding stages
  typedef struct packed {
    logic vld;
    logic can_load;
  } pfc_stage_ctl_t;

endpackage

// ===== hw/rtl/pfc_in_stage.sv =====
// ----------------------------------------------------------------------------
// pfc_in_stage
// Input register: holds one word until the sequencer core takes it.
// ----------------------------------------------------------------------------
module pfc_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pfc_pkg::pfc_in_word_t in_word_i,
  input  logic                  can_load_i,
  output logic                  vld_o,
  output pfc_pkg::pfc_in_word_t word_o
);

  logic                  vld_d, vld_q;
  pfc_pkg::pfc_in_word_t word_q;
  logic                  accept;
  logic                  advance;

  assign advance    = vld_q & can_load_i;
  assign in_stall_o = vld_q & ~can_load_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (advance) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_word_i;
    end
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

endmodule

// ===== hw/rtl/pfc_seq_core.sv =====
// ----------------------------------------------------------------------------
// pfc_seq_core
// Sequencer state, configuration registers and the per-word update logic.
// ----------------------------------------------------------------------------
module pfc_seq_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pfc_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  logic [pfc_pkg::CfgDataWidth-1:0]      cfg_data_i,
  input  logic                                  advance_i,
  input  pfc_pkg::pfc_in_word_t                 word_i,
  output pfc_pkg::pfc_out_word_t                result_o
);

  // configuration
  logic [pfc_pkg::CapWidth-1:0]   prech_volt_q;
  logic [pfc_pkg::TicksWidth-1:0] startup_ticks_q;
  logic [pfc_pkg::TicksWidth-1:0] preload_ticks_q;
  logic [pfc_pkg::PhaseWidth-1:0] phase_limit_q;

  // sequencer state
  pfc_pkg::pfc_state_e              state_d, state_q;
  pfc_pkg::pfc_state_e              prev_d, prev_q;
  logic [pfc_pkg::CountWidth-1:0]   tick_d, tick_q;
  logic [pfc_pkg::CountWidth-1:0]   main_start_d, main_start_q;
  logic                             main_done_d, main_done_q;
  logic                             pre_done_d, pre_done_q;
  logic                             pwm_d, pwm_q;
  logic [pfc_pkg::PulseWidth-1:0]   pulses_d, pulses_q;
  logic [2:0]                       relay_d, relay_q;   // {fans, preload, main}

  pfc_pkg::pfc_op_e                 op;
  logic                             is_tick;
  logic [pfc_pkg::CountWidth-1:0]   main_start_eff;
  logic [pfc_pkg::CountWidth-1:0]   main_elapsed;
  logic [pfc_pkg::PulseWidth-1:0]   pulses_inc;
  logic                             restart;
  logic                             save;
  logic                             err;

  assign op      = pfc_pkg::pfc_op_e'(word_i.opcode);
  assign is_tick = (op == pfc_pkg::OP_TICK);

  // the main state latches its start tick on first entry, then measures from it
  assign main_start_eff = main_done_q ? main_start_q : tick_q;
  assign main_elapsed   = tick_q - main_start_eff;
  assign pulses_inc     = pulses_q + pfc_pkg::PulseWidth'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (op)
      pfc_pkg::OP_TICK: begin
        unique case (state_q)
          pfc_pkg::ST_INIT: begin
            if (tick_q > pfc_pkg::CountWidth'(startup_ticks_q)) begin
              state_d = pfc_pkg::ST_STOP;
            end
          end
          pfc_pkg::ST_SYNC: begin
            if (word_i.period_stable && (word_i.phase_magnitude < phase_limit_q)) begin
              state_d = pfc_pkg::ST_PRE_PREP;
            end
          end
          pfc_pkg::ST_PRE_PREP:  state_d = pfc_pkg::ST_PRECHARGE;
          pfc_pkg::ST_PRECHARGE: begin
            if (word_i.cap_voltage > prech_volt_q) begin
              state_d = pfc_pkg::ST_MAIN;
            end
          end
          pfc_pkg::ST_MAIN: begin
            if (main_elapsed > pfc_pkg::CountWidth'(preload_ticks_q)) begin
              state_d = pfc_pkg::ST_PRE_DIS;
            end
          end
          pfc_pkg::ST_PRE_DIS:  state_d = pfc_pkg::ST_WORK;
          pfc_pkg::ST_CHARGE: begin
            if (pulses_inc >= pfc_pkg::ChargeTicks) begin
              state_d = pfc_pkg::ST_WORK;
            end
          end
          pfc_pkg::ST_STOPPING: state_d = pfc_pkg::ST_STOP;
          default: ;
        endcase
      end
      pfc_pkg::OP_FAULT:    state_d = pfc_pkg::ST_FAULT;
      pfc_pkg::OP_WORK_ON: begin
        if (state_q == pfc_pkg::ST_STOP) begin
          state_d = pfc_pkg::ST_SYNC;
        end
      end
      pfc_pkg::OP_WORK_OFF: state_d = pfc_pkg::ST_STOPPING;
      pfc_pkg::OP_CHARGE_ON: begin
        if (state_q == pfc_pkg::ST_WORK) begin
          state_d = pfc_pkg::ST_CHARGE;
        end
      end
      pfc_pkg::OP_CHARGE_OFF: begin
        if (state_q == pfc_pkg::ST_CHARGE) begin
          state_d = pfc_pkg::ST_WORK;
        end
      end
      pfc_pkg::OP_SAVE:  ;
      pfc_pkg::OP_OTHER: ;
      default: ;
    endcase
  end

  // relays, flags and counters
  always_comb begin
    relay_d      = relay_q;
    main_done_d  = main_done_q;
    pre_done_d   = pre_done_q;
    pwm_d        = pwm_q;
    pulses_d     = pulses_q;
    main_start_d = main_start_q;
    restart      = 1'b0;
    if (is_tick) begin
      unique case (state_q)
        pfc_pkg::ST_INIT, pfc_pkg::ST_STOP: begin
          relay_d     = 3'b000;
          main_done_d = 1'b0;
          pre_done_d  = 1'b0;
          pwm_d       = 1'b0;
        end
        pfc_pkg::ST_SYNC: pwm_d = 1'b0;
        pfc_pkg::ST_PRE_PREP: begin
          pwm_d      = 1'b0;
          pre_done_d = 1'b0;
        end
        pfc_pkg::ST_PRECHARGE: begin
          pwm_d = 1'b0;
          if (!(word_i.cap_voltage > prech_volt_q) && !pre_done_q) begin
            relay_d[1] = 1'b1;
            pre_done_d = 1'b1;
          end
        end
        pfc_pkg::ST_MAIN: begin
          pwm_d = 1'b0;
          if (!main_done_q) begin
            relay_d[0]   = 1'b1;
            relay_d[2]   = 1'b1;
            main_done_d  = 1'b1;
            main_start_d = tick_q;
          end
        end
        pfc_pkg::ST_PRE_DIS: begin
          relay_d[1] = 1'b0;
          pre_done_d = 1'b0;
        end
        pfc_pkg::ST_WORK: pwm_d = 1'b0;
        pfc_pkg::ST_CHARGE: begin
          if (!pwm_q) begin
            pwm_d   = 1'b1;
            restart = 1'b1;
          end
          pulses_d = (pulses_inc >= pfc_pkg::ChargeTicks) ? '0 : pulses_inc;
        end
        pfc_pkg::ST_STOPPING: relay_d = 3'b000;
        pfc_pkg::ST_FAULT: begin
          relay_d = 3'b000;
          pwm_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign prev_d = is_tick ? state_d : prev_q;
  assign tick_d = is_tick ? (tick_q + pfc_pkg::CountWidth'(1)) : tick_q;
  assign save   = (op == pfc_pkg::OP_SAVE) && (state_q == pfc_pkg::ST_STOP);
  assign err    = (op == pfc_pkg::OP_OTHER);

  always_comb begin
    result_o.fsm_state        = state_d;
    result_o.main_relay_on    = relay_d[0];
    result_o.preload_relay_on = relay_d[1];
    result_o.fans_on          = relay_d[2];
    result_o.pwm_enabled      = pwm_d;
    result_o.pwm_restart      = restart;
    result_o.state_changed    = is_tick && (state_d != prev_q);
    result_o.save_request     = save;
    result_o.command_error    = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prech_volt_q    <= pfc_pkg::PrechargeVoltageRst;
      startup_ticks_q <= pfc_pkg::StartupTicksRst;
      preload_ticks_q <= pfc_pkg::PreloadTicksRst;
      phase_limit_q   <= pfc_pkg::SyncPhaseLimitRst;
    end else if (cfg_we_i) begin
      unique case (pfc_pkg::pfc_cfg_idx_e'(cfg_idx_i))
        pfc_pkg::CFG_PRECHARGE_VOLTAGE: prech_volt_q    <= cfg_data_i[pfc_pkg::CapWidth-1:0];
        pfc_pkg::CFG_STARTUP_TICKS:     startup_ticks_q <= cfg_data_i;
        pfc_pkg::CFG_PRELOAD_TICKS:     preload_ticks_q <= cfg_data_i;
        pfc_pkg::CFG_SYNC_PHASE_LIMIT:  phase_limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pfc_pkg::ST_INIT;
      prev_q       <= pfc_pkg::ST_INIT;
      tick_q       <= '0;
      main_start_q <= '0;
      main_done_q  <= 1'b0;
      pre_done_q   <= 1'b0;
      pwm_q        <= 1'b0;
      pulses_q     <= '0;
      relay_q      <= 3'b000;
    end else if (advance_i) begin
      state_q      <= state_d;
      prev_q       <= prev_d;
      tick_q       <= tick_d;
      main_start_q <= main_start_d;
      main_done_q  <= main_done_d;
      pre_done_q   <= pre_done_d;
      pwm_q        <= pwm_d;
      pulses_q     <= pulses_d;
      relay_q      <= relay_d;
    end
  end

endmodule

// ===== hw/rtl/pfc_out_stage.sv =====
// ----------------------------------------------------------------------------
// pfc_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module pfc_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  pfc_pkg::pfc_out_word_t word_i,
  output pfc_pkg::pfc_stage_ctl_t ctl_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output pfc_pkg::pfc_out_word_t out_word_o
);

  logic                   vld_d, vld_q;
  pfc_pkg::pfc_out_word_t word_q;
  logic                   can_load;

  // free when empty, or when the held word leaves this cycle
  assign can_load = ~vld_q | ~out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign ctl_o.vld      = vld_q;
  assign ctl_o.can_load = can_load;
  assign out_valid_o    = vld_q;
  assign out_word_o     = word_q;

endmodule

// ===== hw/rtl/pfc_startup_sequencer.sv =====
// ----------------------------------------------------------------------------
// pfc_startup_sequencer
// Start-up sequencer of a power-factor corrector: relays, fans and PWM enable.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | word
//  in       | input     | in_valid_i / in_stall_o   | in_word_i (pfc_in_word_t)
//  out      | output    | out_valid_o / out_stall_i | out_word_o (pfc_out_word_t)
//  cfg      | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
//  One word per cycle sustained while the output is not stalled; a word passes
//  through the input register, which takes it, then through the result
//  register.
//  The state update is a single pass of compares and counters (32-bit ticks).
//  Reset clears state and loads the register defaults; no clearing pass.
//  A stalled output backs up into the input register, then stalls the input.
// ----------------------------------------------------------------------------
`include "pfc_startup_sequencer_defines.svh"

module pfc_startup_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  pfc_pkg::pfc_in_word_t            in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pfc_pkg::pfc_out_word_t           out_word_o,
  input  logic                             cfg_we_i,
  input  logic [pfc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [pfc_pkg::CfgDataWidth-1:0] cfg_data_i
);

  pfc_pkg::pfc_stage_ctl_t out_ctl;
  pfc_pkg::pfc_in_word_t   item;
  pfc_pkg::pfc_out_word_t  result;
  logic                    item_vld;
  logic                    advance;
  logic                    restart_seen;
  logic                    save_seen;
  logic                    err_seen;

  assign advance = item_vld & out_ctl.can_load;

  pfc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .can_load_i (out_ctl.can_load),
    .vld_o      (item_vld),
    .word_o     (item)
  );

  pfc_seq_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (advance),
    .word_i     (item),
    .result_o   (result)
  );

  pfc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .word_i      (result),
    .ctl_o       (out_ctl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  assign restart_seen = out_valid_o & out_word_o.pwm_restart;
  assign save_seen    = out_valid_o & out_word_o.save_request;
  assign err_seen     = out_valid_o & out_word_o.command_error;

  `PFC_ASSERT_IMP(a_restart_pwm, clk_i, rst_ni, restart_seen, out_word_o.pwm_enabled)
  `PFC_ASSERT_IMP(a_save_in_stop, clk_i, rst_ni, save_seen, out_word_o.fsm_state == pfc_pkg::ST_STOP)
  `PFC_ASSERT_IMP(a_err_no_change, clk_i, rst_ni, err_seen, !out_word_o.state_changed)
  `PFC_ASSERT_NXT(a_advance_lands, clk_i, rst_ni, advance, out_valid_o && out_ctl.vld)

endmodule

// ===== bench/tb_pfc_startup_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_pfc_startup_sequencer
// Self-checking bench for the PFC start-up sequencer. A directed table walks
// the power-up path, the commands and the register defaults. A guided random
// walk then drives the start-up sequence under several register settings,
// with noise words and random idling on both channels. Every result word is
// checked field by field against its table row or a cycle-free state model.
// ----------------------------------------------------------------------------
module tb_pfc_startup_sequencer;

  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned HoldLen       = 64;
  localparam int unsigned ItemsPerPhase = 150;
  localparam int unsigned NumPhases     = 7;

  typedef struct {
    pfc_pkg::pfc_op_e               op;
    logic [pfc_pkg::CapWidth-1:0]   cap;
    logic                           stable;
    logic [pfc_pkg::PhaseWidth-1:0] phase;
    bit                             has_want;
    pfc_pkg::pfc_out_word_t         want;
  } stim_row_t;

  logic                             clk_i      = 1'b0;
  logic                             rst_ni     = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  pfc_pkg::pfc_in_word_t            in_word_i  = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  pfc_pkg::pfc_out_word_t           out_word_o;
  logic                             cfg_we_i   = 1'b0;
  logic [pfc_pkg::CfgIdxWidth-1:0]  cfg_idx_i  = '0;
  logic [pfc_pkg::CfgDataWidth-1:0] cfg_data_i = '0;

  // model of the sequencer
  pfc_pkg::pfc_state_e            pred_state = pfc_pkg::ST_INIT;
  pfc_pkg::pfc_state_e            pred_prev  = pfc_pkg::ST_INIT;
  logic [pfc_pkg::CountWidth-1:0] tick_cnt   = '0;
  logic [pfc_pkg::CountWidth-1:0] main_t0    = '0;
  logic                           main_done  = 1'b0;
  logic                           pre_done   = 1'b0;
  logic                           pwm_on     = 1'b0;
  logic [pfc_pkg::PulseWidth-1:0] chg_cnt    = '0;
  logic                           rly_main   = 1'b0;
  logic                           rly_pre    = 1'b0;
  logic                           rly_fans   = 1'b0;
  logic [pfc_pkg::CapWidth-1:0]   cfg_pv      = pfc_pkg::PrechargeVoltageRst;
  logic [pfc_pkg::TicksWidth-1:0] cfg_startup = pfc_pkg::StartupTicksRst;
  logic [pfc_pkg::TicksWidth-1:0] cfg_preload = pfc_pkg::PreloadTicksRst;
  logic [pfc_pkg::PhaseWidth-1:0] cfg_sync    = pfc_pkg::SyncPhaseLimitRst;

  pfc_pkg::pfc_out_word_t pending_status[$];
  int unsigned   fails        = 0;
  int unsigned   n_sent       = 0;
  int unsigned   tx_idle_pct  = 0;
  int unsigned   rx_idle_pct  = 0;
  int unsigned   hold_reqs    = 0;
  int unsigned   hold_seen    = 0;
  int unsigned   hold_left    = 0;
  int unsigned   stuck_cycles = 0;

  pfc_startup_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic pfc_pkg::pfc_out_word_t quiet_status(pfc_pkg::pfc_state_e s, bit chg,
                                                          bit sv, bit er);
    pfc_pkg::pfc_out_word_t r;
    r = '0;
    r.fsm_state     = s;
    r.state_changed = chg;
    r.save_request  = sv;
    r.command_error = er;
    return r;
  endfunction

  function automatic pfc_pkg::pfc_out_word_t advance_sequencer(pfc_pkg::pfc_in_word_t w);
    pfc_pkg::pfc_out_word_t         res;
    logic [pfc_pkg::CountWidth-1:0] dly;
    bit                             restart, changed, save, err;
    restart = 0;
    changed = 0;
    save    = 0;
    err     = 0;
    case (pfc_pkg::pfc_op_e'(w.opcode))
      pfc_pkg::OP_TICK: begin
        case (pred_state)
          pfc_pkg::ST_INIT, pfc_pkg::ST_STOP: begin
            {rly_main, rly_pre, rly_fans} = '0;
            main_done = 1'b0;
            pre_done  = 1'b0;
            pwm_on    = 1'b0;
            if (pred_state == pfc_pkg::ST_INIT &&
                tick_cnt > pfc_pkg::CountWidth'(cfg_startup)) begin
              pred_state = pfc_pkg::ST_STOP;
            end
          end
          pfc_pkg::ST_SYNC: begin
            pwm_on = 1'b0;
            if (w.period_stable && w.phase_magnitude < cfg_sync)
              pred_state = pfc_pkg::ST_PRE_PREP;
          end
          pfc_pkg::ST_PRE_PREP: begin
            pwm_on     = 1'b0;
            pre_done   = 1'b0;
            pred_state = pfc_pkg::ST_PRECHARGE;
          end
          pfc_pkg::ST_PRECHARGE: begin
            pwm_on = 1'b0;
            if (w.cap_voltage > cfg_pv) begin
              pred_state = pfc_pkg::ST_MAIN;
            end else if (!pre_done) begin
              rly_pre  = 1'b1;
              pre_done = 1'b1;
            end
          end
          pfc_pkg::ST_MAIN: begin
            pwm_on = 1'b0;
            if (!main_done) begin
              rly_main  = 1'b1;
              rly_fans  = 1'b1;
              main_done = 1'b1;
              main_t0   = tick_cnt;
            end
            dly = tick_cnt - main_t0;
            if (dly > pfc_pkg::CountWidth'(cfg_preload)) pred_state = pfc_pkg::ST_PRE_DIS;
          end
          pfc_pkg::ST_PRE_DIS: begin
            rly_pre    = 1'b0;
            pre_done   = 1'b0;
            pred_state = pfc_pkg::ST_WORK;
          end
          pfc_pkg::ST_WORK: pwm_on = 1'b0;
          pfc_pkg::ST_CHARGE: begin
            if (!pwm_on) begin
              pwm_on  = 1'b1;
              restart = 1;
            end
            chg_cnt = chg_cnt + pfc_pkg::PulseWidth'(1);
            if (chg_cnt >= pfc_pkg::ChargeTicks) begin
              chg_cnt    = '0;
              pred_state = pfc_pkg::ST_WORK;
            end
          end
          pfc_pkg::ST_STOPPING: begin
            {rly_main, rly_pre, rly_fans} = '0;
            pred_state = pfc_pkg::ST_STOP;
          end
          pfc_pkg::ST_FAULT: begin
            {rly_main, rly_pre, rly_fans} = '0;
            pwm_on = 1'b0;
          end
          default: ;
        endcase
        changed   = (pred_state != pred_prev);
        pred_prev = pred_state;
        tick_cnt  = tick_cnt + pfc_pkg::CountWidth'(1);
      end
      pfc_pkg::OP_FAULT:      pred_state = pfc_pkg::ST_FAULT;
      pfc_pkg::OP_WORK_ON:
        if (pred_state == pfc_pkg::ST_STOP) pred_state = pfc_pkg::ST_SYNC;
      pfc_pkg::OP_WORK_OFF:   pred_state = pfc_pkg::ST_STOPPING;
      pfc_pkg::OP_CHARGE_ON:
        if (pred_state == pfc_pkg::ST_WORK) pred_state = pfc_pkg::ST_CHARGE;
      pfc_pkg::OP_CHARGE_OFF:
        if (pred_state == pfc_pkg::ST_CHARGE) pred_state = pfc_pkg::ST_WORK;
      pfc_pkg::OP_SAVE:       save = (pred_state == pfc_pkg::ST_STOP);
      default:                err = 1;
    endcase
    res = '0;
    res.fsm_state        = pred_state;
    res.main_relay_on    = rly_main;
    res.preload_relay_on = rly_pre;
    res.fans_on          = rly_fans;
    res.pwm_enabled      = pwm_on;
    res.pwm_restart      = restart;
    res.state_changed    = changed;
    res.save_request     = save;
    res.command_error    = err;
    return res;
  endfunction

  // random word steered by the modelled state so the walk gets past sync
  function automatic pfc_pkg::pfc_in_word_t pick_word();
    pfc_pkg::pfc_in_word_t w;
    int unsigned           r, k;
    r = $urandom_range(99);
    k = $urandom_range(3);
    w.opcode          = pfc_pkg::OP_TICK;
    w.cap_voltage     = pfc_pkg::CapWidth'($urandom);
    w.period_stable   = 1'($urandom);
    w.phase_magnitude = pfc_pkg::PhaseWidth'($urandom);
    if (r < 10) begin
      w.opcode = 3'($urandom);
      return w;
    end
    if (r < 13) begin
      w.opcode = (r == 10) ? pfc_pkg::OP_FAULT : pfc_pkg::OP_WORK_OFF;
      return w;
    end
    r = $urandom_range(99);
    case (pred_state)
      pfc_pkg::ST_INIT: if (r < 8) w.opcode = pfc_pkg::OP_WORK_OFF;
      pfc_pkg::ST_STOP: begin
        if (r < 60) w.opcode = pfc_pkg::OP_WORK_ON;
        else if (r < 72) w.opcode = pfc_pkg::OP_SAVE;
      end
      pfc_pkg::ST_SYNC: begin
        w.period_stable = (r < 80);
        if (k != 0)
          w.phase_magnitude = cfg_sync + pfc_pkg::PhaseWidth'($urandom_range(6))
                              - pfc_pkg::PhaseWidth'(3);
      end
      pfc_pkg::ST_PRECHARGE: begin
        if (k == 0) w.cap_voltage = cfg_pv;
        else if (k == 1) w.cap_voltage = cfg_pv + pfc_pkg::CapWidth'(1);
      end
      pfc_pkg::ST_WORK: begin
        if (r < 30) w.opcode = pfc_pkg::OP_CHARGE_ON;
        else if (r < 34) w.opcode = pfc_pkg::OP_SAVE;
      end
      pfc_pkg::ST_CHARGE: if (r < 12) w.opcode = pfc_pkg::OP_CHARGE_OFF;
      pfc_pkg::ST_FAULT:  if (r < 30) w.opcode = pfc_pkg::OP_WORK_OFF;
      default: ;
    endcase
    return w;
  endfunction

  task automatic offer_word(pfc_pkg::pfc_in_word_t w, bit has_want,
                            pfc_pkg::pfc_out_word_t want);
    pfc_pkg::pfc_out_word_t res;
    if (n_sent < 350) begin
      tx_idle_pct = 18;
      rx_idle_pct = 48;
    end else if (n_sent < 700) begin
      tx_idle_pct = 48;
      rx_idle_pct = 18;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    res = advance_sequencer(w);
    pending_status.push_back(has_want ? want : res);
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(pfc_pkg::pfc_cfg_idx_e idx, logic [pfc_pkg::CfgDataWidth-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_settings(logic [pfc_pkg::CapWidth-1:0] pv,
                               logic [pfc_pkg::TicksWidth-1:0] st,
                               logic [pfc_pkg::TicksWidth-1:0] pl,
                               logic [pfc_pkg::PhaseWidth-1:0] sl);
    put_reg(pfc_pkg::CFG_PRECHARGE_VOLTAGE, pfc_pkg::CfgDataWidth'(pv));
    put_reg(pfc_pkg::CFG_STARTUP_TICKS, st);
    put_reg(pfc_pkg::CFG_PRELOAD_TICKS, pl);
    put_reg(pfc_pkg::CFG_SYNC_PHASE_LIMIT, sl);
    cfg_we_i    <= 1'b0;
    cfg_pv      = pv;
    cfg_startup = st;
    cfg_preload = pl;
    cfg_sync    = sl;
  endtask

  task automatic note_fail(string what, logic [15:0] want, logic [15:0] got);
    fails++;
    if (fails <= 10) $display("mismatch in %s: expected %0h, got %0h", what, want, got);
  endtask

  // result side: random stall, long hold-off on request, and the checks
  always @(posedge clk_i) begin
    pfc_pkg::pfc_out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        note_fail("unexpected word", '0, 16'(out_word_o));
      end else begin
        want = pending_status.pop_front();
        if (out_word_o.fsm_state !== want.fsm_state)
          note_fail("fsm_state", 16'(want.fsm_state), 16'(out_word_o.fsm_state));
        if (out_word_o.main_relay_on !== want.main_relay_on)
          note_fail("main_relay_on", 16'(want.main_relay_on), 16'(out_word_o.main_relay_on));
        if (out_word_o.preload_relay_on !== want.preload_relay_on)
          note_fail("preload_relay_on", 16'(want.preload_relay_on),
                    16'(out_word_o.preload_relay_on));
        if (out_word_o.fans_on !== want.fans_on)
          note_fail("fans_on", 16'(want.fans_on), 16'(out_word_o.fans_on));
        if (out_word_o.pwm_enabled !== want.pwm_enabled)
          note_fail("pwm_enabled", 16'(want.pwm_enabled), 16'(out_word_o.pwm_enabled));
        if (out_word_o.pwm_restart !== want.pwm_restart)
          note_fail("pwm_restart", 16'(want.pwm_restart), 16'(out_word_o.pwm_restart));
        if (out_word_o.state_changed !== want.state_changed)
          note_fail("state_changed", 16'(want.state_changed), 16'(out_word_o.state_changed));
        if (out_word_o.save_request !== want.save_request)
          note_fail("save_request", 16'(want.save_request), 16'(out_word_o.save_request));
        if (out_word_o.command_error !== want.command_error)
          note_fail("command_error", 16'(want.command_error), 16'(out_word_o.command_error));
      end
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen   <= hold_reqs;
      hold_left   <= HoldLen;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    stim_row_t             dir_tab[$];
    pfc_pkg::pfc_in_word_t w;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // power-up path under the reset register values
    dir_tab.push_back('{pfc_pkg::OP_OTHER, 12'hFFF, 1'b1, 16'hFFFF, 1,
                        quiet_status(pfc_pkg::ST_INIT, 0, 0, 1)});
    dir_tab.push_back('{pfc_pkg::OP_SAVE, 12'h000, 1'b0, 16'h0000, 1,
                        quiet_status(pfc_pkg::ST_INIT, 0, 0, 0)});
    dir_tab.push_back('{pfc_pkg::OP_TICK, 12'h000, 1'b0, 16'h0000, 1,
                        quiet_status(pfc_pkg::ST_INIT, 0, 0, 0)});
    dir_tab.push_back('{pfc_pkg::OP_WORK_ON, 12'h000, 1'b0, 16'h0000, 1,
                        quiet_status(pfc_pkg::ST_INIT, 0, 0, 0)});
    dir_tab.push_back('{pfc_pkg::OP_CHARGE_ON, 12'hFFF, 1'b1, 16'hFFFF, 1,
                        quiet_status(pfc_pkg::ST_INIT, 0, 0, 0)});
    dir_tab.push_back('{pfc_pkg::OP_CHARGE_OFF, 12'h000, 1'b0, 16'h0000, 1,
                        quiet_status(pfc_pkg::ST_INIT, 0, 0, 0)});
    dir_tab.push_back('{pfc_pkg::OP_WORK_OFF, 12'h000, 1'b0, 16'h0000, 1,
                        quiet_status(pfc_pkg::ST_STOPPING, 0, 0, 0)});
    dir_tab.push_back('{pfc_pkg::OP_TICK, 12'hFFF, 1'b1, 16'hFFFF, 1,
                        quiet_status(pfc_pkg::ST_STOP, 1, 0, 0)});
    dir_tab.push_back('{pfc_pkg::OP_SAVE, 12'h000, 1'b0, 16'h0000, 1,
                        quiet_status(pfc_pkg::ST_STOP, 0, 1, 0)});
    dir_tab.push_back('{pfc_pkg::OP_WORK_ON, 12'h000, 1'b0, 16'h0000, 1,
                        quiet_status(pfc_pkg::ST_SYNC, 0, 0, 0)});
    dir_tab.push_back('{pfc_pkg::OP_TICK, 12'h000, 1'b0, 16'h0000, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_TICK, 12'h000, 1'b1, 16'd1024, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_TICK, 12'h000, 1'b1, 16'd1023, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_TICK, 12'h000, 1'b0, 16'hFFFF, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_TICK, 12'd2048, 1'b0, 16'h0000, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_TICK, 12'd2049, 1'b0, 16'h0000, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_TICK, 12'h000, 1'b0, 16'h0000, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_CHARGE_ON, 12'h000, 1'b0, 16'h0000, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_FAULT, 12'h000, 1'b0, 16'h0000, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_TICK, 12'h000, 1'b0, 16'h0000, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_SAVE, 12'h000, 1'b0, 16'h0000, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_WORK_OFF, 12'h000, 1'b0, 16'h0000, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_TICK, 12'h000, 1'b0, 16'h0000, 0, '0});
    dir_tab.push_back('{pfc_pkg::OP_OTHER, 12'h000, 1'b0, 16'h0000, 0, '0});

    foreach (dir_tab[i]) begin
      w.opcode          = dir_tab[i].op;
      w.cap_voltage     = dir_tab[i].cap;
      w.period_stable   = dir_tab[i].stable;
      w.phase_magnitude = dir_tab[i].phase;
      offer_word(w, dir_tab[i].has_want, dir_tab[i].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      case (p)
        0: load_settings(12'd1000, 16'd2, 16'd3, 16'd30000);
        1: load_settings(12'd0, 16'd0, 16'd0, 16'hFFFF);
        2: load_settings(12'hFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        default: load_settings(pfc_pkg::CapWidth'($urandom),
                               pfc_pkg::TicksWidth'($urandom_range(10)),
                               pfc_pkg::TicksWidth'($urandom_range(12)),
                               pfc_pkg::PhaseWidth'($urandom));
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        // long result stall while words keep coming, so the input backs up
        if (p == 3 && i == 40) hold_reqs++;
        // let everything in flight come out before carrying on
        if (p == 4 && i == 75) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (pending_status.size() != 0);
        end
        offer_word(pick_word(), 0, '0);
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
